// File: rtl/core/lhc_pkg.sv
package lhc_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int CODE_BITS   = 16;
    localparam int LEN_W       = 5;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_DECODE   = 2'd1;
    localparam logic [1:0] CMD_ENCODE   = 2'd2;
    localparam logic [1:0] CMD_VALIDATE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [0:0] CFG_MAX_LEN = 1'b0;
    localparam logic [0:0] CFG_SYMBOLS = 1'b1;

    // search token walking down the cell row
    typedef struct packed {
        logic                 valid;
        logic [1:0]           mode;
        logic [IDX_W-1:0]     idx;
        logic [CODE_BITS-1:0] key_pat;
        logic [LEN_W-1:0]     key_len;
        logic                 found;
        logic [IDX_W-1:0]     sym;
        logic                 cap;
        logic [CODE_BITS-1:0] cap_pat;
        logic [LEN_W-1:0]     cap_len;
        logic                 fault;
    } t_probe;

    function automatic logic [CODE_BITS-1:0] mask_of(input logic [LEN_W-1:0] n);
        logic [CODE_BITS:0] m;
        m = (17'd1 << n) - 17'd1;
        if (n >= LEN_W'(CODE_BITS)) begin
            return '1;
        end
        return m[CODE_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/lsb_first_huffman_codec.sv
// channel   direction  handshake                      payload
// in        input      i_in_valid / o_in_ready        command, entry fields, stream bit
// out       output     o_out_valid / i_out_ready      status, done, symbol, pattern, length
// cfg       input      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
// load and requests rejected up front answer in the cycle after they are taken, with no row pass
// decode and encode make one pass of the token down the 64-cell row
// validate makes one row pass per entry checked and stops at a fault
// synchronous active-low reset clears the decode accumulator and control state
// a new request is taken once the previous result is taken or leaving
module lsb_first_huffman_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_entry_index,
    input  logic [4:0]  i_entry_length,
    input  logic [15:0] i_entry_pattern,
    input  logic        i_stream_bit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_done_res,
    output logic [5:0]  o_decoded_symbol,
    output logic [15:0] o_code_pattern,
    output logic [4:0]  o_code_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import lhc_pkg::*;

    logic [LEN_W-1:0]     r_max_len;
    logic [CNT_W-1:0]     r_used_cfg;
    logic [CODE_BITS-1:0] r_acc;
    logic [LEN_W-1:0]     r_gath;
    logic                 r_busy;
    logic [IDX_W-1:0]     r_vidx;
    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic                 r_done;
    logic [IDX_W-1:0]     r_sym;
    logic [CODE_BITS-1:0] r_pat;
    logic [LEN_W-1:0]     r_len;
    t_probe               r_launch;

    logic [LEN_W-1:0]     n_max_len;
    logic [CNT_W-1:0]     n_used_cfg;
    logic [CODE_BITS-1:0] n_acc;
    logic [LEN_W-1:0]     n_gath;
    logic                 n_busy;
    logic [IDX_W-1:0]     n_vidx;
    logic                 n_out_valid;
    logic [1:0]           n_status;
    logic                 n_done;
    logic [IDX_W-1:0]     n_sym;
    logic [CODE_BITS-1:0] n_pat;
    logic [LEN_W-1:0]     n_len;
    t_probe               n_launch;

    t_probe               w_exit;
    t_probe               start_probe;
    logic                 take;
    logic                 load_en;
    logic [CNT_W-1:0]     used;
    logic [CODE_BITS-1:0] acc_in;
    logic [LEN_W-1:0]     gath_in;
    logic [IDX_W-1:0]     vidx_inc;

    assign used        = (r_used_cfg > CNT_W'(NUM_ENTRIES)) ? CNT_W'(NUM_ENTRIES) : r_used_cfg;
    assign o_in_ready  = !r_busy && (!r_out_valid || i_out_ready);
    assign take        = i_in_valid && o_in_ready;
    assign load_en     = take && i_command == CMD_LOAD;
    assign o_cfg_ready = 1'b1;
    assign vidx_inc    = r_vidx + IDX_W'(1);

    always_comb begin
        acc_in = r_acc;
        if (r_gath < LEN_W'(CODE_BITS)) begin
            acc_in = r_acc | (CODE_BITS'(i_stream_bit) << r_gath[3:0]);
        end
        gath_in = r_gath + LEN_W'(1);
    end

    always_comb begin
        start_probe         = '0;
        start_probe.valid   = 1'b1;
        start_probe.mode    = i_command;
        start_probe.idx     = (i_command == CMD_VALIDATE) ? '0 : i_entry_index;
        start_probe.key_pat = acc_in;
        start_probe.key_len = gath_in;
    end

    lhc_chain u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_used     (used),
        .i_max_len  (r_max_len),
        .i_load_en  (load_en),
        .i_load_idx (i_entry_index),
        .i_load_len (i_entry_length),
        .i_load_pat (i_entry_pattern),
        .i_probe    (r_launch),
        .o_probe    (w_exit)
    );

    always_comb begin
        n_max_len      = r_max_len;
        n_used_cfg     = r_used_cfg;
        n_acc          = r_acc;
        n_gath         = r_gath;
        n_busy         = r_busy;
        n_vidx         = r_vidx;
        n_out_valid    = r_out_valid;
        n_status       = r_status;
        n_done         = r_done;
        n_sym          = r_sym;
        n_pat          = r_pat;
        n_len          = r_len;
        n_launch       = r_launch;
        n_launch.valid = 1'b0;
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MAX_LEN) begin
                n_max_len = i_cfg_data[LEN_W-1:0];
            end else begin
                n_used_cfg = i_cfg_data;
            end
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (take) begin
            n_status = ST_OK;
            n_done   = 1'b1;
            n_sym    = '0;
            n_pat    = '0;
            n_len    = '0;
            case (i_command)
                CMD_LOAD: begin
                    n_out_valid = 1'b1;
                end
                CMD_DECODE: begin
                    if (r_max_len == '0) begin
                        n_status    = ST_MALFORMED;
                        n_out_valid = 1'b1;
                        n_acc       = '0;
                        n_gath      = '0;
                    end else begin
                        n_acc    = acc_in;
                        n_gath   = gath_in;
                        n_launch = start_probe;
                        n_busy   = 1'b1;
                    end
                end
                CMD_ENCODE: begin
                    if ({1'b0, i_entry_index} >= used) begin
                        n_status    = ST_INVALID;
                        n_out_valid = 1'b1;
                    end else begin
                        n_launch = start_probe;
                        n_busy   = 1'b1;
                    end
                end
                default: begin
                    if (used == '0 || r_max_len == '0 ||
                        r_max_len > LEN_W'(CODE_BITS)) begin
                        n_status    = ST_INVALID;
                        n_out_valid = 1'b1;
                    end else begin
                        n_vidx   = '0;
                        n_launch = start_probe;
                        n_busy   = 1'b1;
                    end
                end
            endcase
        end
        if (w_exit.valid) begin
            case (w_exit.mode)
                CMD_DECODE: begin
                    n_busy      = 1'b0;
                    n_out_valid = 1'b1;
                    if (w_exit.found) begin
                        n_sym  = w_exit.sym;
                        n_acc  = '0;
                        n_gath = '0;
                    end else if (r_gath >= r_max_len) begin
                        n_status = ST_MALFORMED;
                        n_acc    = '0;
                        n_gath   = '0;
                    end else begin
                        n_done = 1'b0;
                    end
                end
                CMD_ENCODE: begin
                    n_busy      = 1'b0;
                    n_out_valid = 1'b1;
                    if (w_exit.cap_len == '0 || w_exit.cap_len > r_max_len) begin
                        n_status = ST_MALFORMED;
                    end else begin
                        n_pat = w_exit.cap_pat & mask_of(w_exit.cap_len);
                        n_len = w_exit.cap_len;
                    end
                end
                default: begin
                    if (w_exit.fault) begin
                        n_status    = ST_MALFORMED;
                        n_busy      = 1'b0;
                        n_out_valid = 1'b1;
                    end else if ({1'b0, r_vidx} + CNT_W'(1) == used) begin
                        n_busy      = 1'b0;
                        n_out_valid = 1'b1;
                    end else begin
                        n_vidx         = vidx_inc;
                        n_launch.valid = 1'b1;
                        n_launch.mode  = CMD_VALIDATE;
                        n_launch.idx   = vidx_inc;
                        n_launch.found = 1'b0;
                        n_launch.cap   = 1'b0;
                        n_launch.fault = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= LEN_W'(16);
            r_used_cfg  <= CNT_W'(64);
            r_acc       <= '0;
            r_gath      <= '0;
            r_busy      <= 1'b0;
            r_vidx      <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_done      <= 1'b0;
            r_sym       <= '0;
            r_pat       <= '0;
            r_len       <= '0;
            r_launch    <= '0;
        end else begin
            r_max_len   <= n_max_len;
            r_used_cfg  <= n_used_cfg;
            r_acc       <= n_acc;
            r_gath      <= n_gath;
            r_busy      <= n_busy;
            r_vidx      <= n_vidx;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_done      <= n_done;
            r_sym       <= n_sym;
            r_pat       <= n_pat;
            r_len       <= n_len;
            r_launch    <= n_launch;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_done_res       = r_done;
    assign o_decoded_symbol = r_sym;
    assign o_code_pattern   = r_pat;
    assign o_code_length    = r_len;

endmodule

// File: rtl/core/lhc_cell.sv
module lhc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lhc_pkg::IDX_W-1:0]     i_pos,
    input  logic [lhc_pkg::CNT_W-1:0]     i_used,
    input  logic [lhc_pkg::LEN_W-1:0]     i_max_len,
    input  logic                        i_load_en,
    input  logic [lhc_pkg::IDX_W-1:0]     i_load_idx,
    input  logic [lhc_pkg::LEN_W-1:0]     i_load_len,
    input  logic [lhc_pkg::CODE_BITS-1:0] i_load_pat,
    input  lhc_pkg::t_probe             i_probe,
    output lhc_pkg::t_probe             o_probe
);
    import lhc_pkg::*;

    logic [LEN_W-1:0]     r_len;
    logic [CODE_BITS-1:0] r_pat;
    t_probe               r_probe;
    t_probe               n_probe;
    logic                 in_use;
    logic [LEN_W-1:0]     short_len;
    logic [CODE_BITS-1:0] short_pat;
    logic [CODE_BITS-1:0] long_pat;

    assign in_use = {1'b0, i_pos} < i_used;

    always_ff @(posedge i_clk) begin
        if (i_load_en && i_load_idx == i_pos) begin
            r_len <= i_load_len;
            r_pat <= i_load_pat;
        end
    end

    always_comb begin
        n_probe = i_probe;
        if (r_len < i_probe.cap_len) begin
            short_len = r_len;
            short_pat = r_pat;
            long_pat  = i_probe.cap_pat;
        end else begin
            short_len = i_probe.cap_len;
            short_pat = i_probe.cap_pat;
            long_pat  = r_pat;
        end
        case (i_probe.mode)
            CMD_DECODE: begin
                if (in_use && !i_probe.found && r_len == i_probe.key_len &&
                    r_pat == i_probe.key_pat) begin
                    n_probe.found = 1'b1;
                    n_probe.sym   = i_pos;
                end
            end
            CMD_ENCODE: begin
                if (i_pos == i_probe.idx) begin
                    n_probe.cap     = 1'b1;
                    n_probe.cap_len = r_len;
                    n_probe.cap_pat = r_pat;
                end
            end
            CMD_VALIDATE: begin
                if (i_pos == i_probe.idx) begin
                    n_probe.cap     = 1'b1;
                    n_probe.cap_len = r_len;
                    n_probe.cap_pat = r_pat;
                    if (r_len == '0 || r_len > i_max_len ||
                        (r_pat & ~mask_of(r_len)) != '0) begin
                        n_probe.fault = 1'b1;
                    end
                end else if (i_pos > i_probe.idx && in_use && i_probe.cap) begin
                    // prefix of one code is another code
                    if ((long_pat & mask_of(short_len)) == short_pat) begin
                        n_probe.fault = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

// File: rtl/core/lhc_chain.sv
module lhc_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lhc_pkg::CNT_W-1:0]     i_used,
    input  logic [lhc_pkg::LEN_W-1:0]     i_max_len,
    input  logic                        i_load_en,
    input  logic [lhc_pkg::IDX_W-1:0]     i_load_idx,
    input  logic [lhc_pkg::LEN_W-1:0]     i_load_len,
    input  logic [lhc_pkg::CODE_BITS-1:0] i_load_pat,
    input  lhc_pkg::t_probe             i_probe,
    output lhc_pkg::t_probe             o_probe
);
    import lhc_pkg::*;

    t_probe w_link [0:NUM_ENTRIES];

    assign w_link[0] = i_probe;

    for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
        lhc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pos      (IDX_W'(k)),
            .i_used     (i_used),
            .i_max_len  (i_max_len),
            .i_load_en  (i_load_en),
            .i_load_idx (i_load_idx),
            .i_load_len (i_load_len),
            .i_load_pat (i_load_pat),
            .i_probe    (w_link[k]),
            .o_probe    (w_link[k+1])
        );
    end

    assign o_probe = w_link[NUM_ENTRIES];

endmodule
